// File: hdl/vna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared widths, codes, beat types and state encodings of the accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int CNT_W    = 13;
  localparam int IDX_W    = 16;
  localparam int CMP_W    = 17;
  localparam int POS_W    = 24;
  localparam int DIFF_W   = 25;
  localparam int PROD_W   = 50;
  localparam int CROSS_W  = 51;
  localparam int SUM_W    = 32;
  localparam int NRM_W    = 16;
  localparam int MAG_KEEP = 30;
  localparam int SQ_W     = 60;
  localparam int ACC_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int DIV_W    = 46;
  localparam int Q_W      = 15;
  localparam int Q_FRAC   = 14;
  localparam logic [Q_W-1:0] Q14_ONE = 15'd16384;
  localparam logic [ACC_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_QUAD = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic [IDX_W-1:0]        index_d;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TRI,
    OP_QUAD,
    OP_READ,
    OP_SKIP,
    OP_BAD
  } job_op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos3_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum3_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } nrm3_t;

  typedef struct packed {
    job_op_t               op;
    logic [3:0][IDX_W-1:0] idx;
    pos3_t                 pos;
  } job_t;

  typedef struct packed {
    logic  start;
    vec3_t vec;
  } norm_req_t;

  typedef struct packed {
    logic  done;
    nrm3_t n;
  } norm_rsp_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SHIFT,
    NS_SQUARE,
    NS_SQRT,
    NS_DIV_LOAD,
    NS_DIV,
    NS_DONE
  } norm_state_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_LOAD,
    BS_POS_RD,
    BS_POS_CAP,
    BS_DIFF,
    BS_MUL,
    BS_MACC,
    BS_NORM_GO,
    BS_NORM_WAIT,
    BS_ACC_RD,
    BS_ACC_WR,
    BS_SUM_RD,
    BS_SUM_CAP,
    BS_RESULT
  } back_state_t;

endpackage

// File: hdl/vna_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator front end
// Holds the vertex count register, checks indices and queues decoded jobs.
// ----------------------------------------------------------------------------
module vna_front #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  vna_pkg::in_item_t         in_data,
  input  logic                      cfg_we,
  input  logic [vna_pkg::CNT_W-1:0] cfg_data,
  output logic                      q_push,
  output vna_pkg::job_t             q_wdata,
  input  logic                      q_full
);
  import vna_pkg::*;

  localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_VERTICES);

  logic [CNT_W-1:0] vertex_count_r;
  logic [CMP_W-1:0] eff_cnt;
  logic             a_ok, b_ok, c_ok, d_ok;
  job_op_t          op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
    end else if (cfg_we) begin
      vertex_count_r <= cfg_data;
    end
  end

  always_comb begin
    eff_cnt = (CMP_W'(vertex_count_r) < MAX_LIM) ? CMP_W'(vertex_count_r) : MAX_LIM;
    a_ok    = CMP_W'(in_data.index_a) < eff_cnt;
    b_ok    = CMP_W'(in_data.index_b) < eff_cnt;
    c_ok    = CMP_W'(in_data.index_c) < eff_cnt;
    d_ok    = CMP_W'(in_data.index_d) < eff_cnt;
    unique case (in_data.cmd)
      CMD_LOAD: op = a_ok ? OP_LOAD : OP_BAD;
      CMD_TRI:  op = (a_ok && b_ok && c_ok) ? OP_TRI : OP_SKIP;
      CMD_QUAD: op = (a_ok && b_ok && c_ok && d_ok) ? OP_QUAD : OP_SKIP;
      CMD_READ: op = a_ok ? OP_READ : OP_BAD;
      default:  op = OP_BAD;
    endcase
  end

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign q_wdata.op = op;
  assign q_wdata.idx = {in_data.index_d, in_data.index_c, in_data.index_b, in_data.index_a};
  assign q_wdata.pos = {in_data.pos_x, in_data.pos_y, in_data.pos_z};

endmodule

// File: hdl/vna_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator job queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module vna_queue #(
  parameter int DEPTH = vna_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vna_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output vna_pkg::job_t rdata,
  output logic          valid
);
  import vna_pkg::*;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  job_t              slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

  assign full  = (fill_r == FILL_W'(DEPTH));
  assign valid = (fill_r != '0);
  assign rdata = slot_r[rd_ptr_r];

endmodule

// File: hdl/vna_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator normalizer
// Scales a signed 3-vector to a unit vector in Q1.14: shift, sum of squares,
// bit-serial square root and three restoring divisions.
// ----------------------------------------------------------------------------
module vna_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  vna_pkg::norm_req_t  req,
  output vna_pkg::norm_rsp_t  rsp
);
  import vna_pkg::*;

  norm_state_t              state_r, state_nxt;
  logic [CROSS_W-1:0]       m_r [3];
  logic                     neg_r [3];
  logic signed [CROSS_W-1:0] vin [3];
  logic [ACC_W-1:0]         s_r, res_r, bit_r;
  logic [SQ_W-1:0]          sq_r;
  logic [1:0]               scnt_r;
  logic [ROOT_W-1:0]        len_r;
  logic [DIV_W-1:0]         rem_r;
  logic [3:0]               qidx_r;
  logic [1:0]               ccnt_r;
  logic [Q_W-1:0]           qacc_r;
  logic [Q_W-1:0]           q_r [3];

  logic                     big_any;
  logic [MAG_KEEP-1:0]      sq_in;
  logic [ACC_W-1:0]         trial_s, res_step;
  logic                     s_ge;
  logic [DIV_W-1:0]         trial_d, num;
  logic                     d_ge;
  logic [Q_W-1:0]           qacc_step, qcap;
  logic signed [NRM_W-1:0]  nval [3];

  assign vin[0] = req.vec.x;
  assign vin[1] = req.vec.y;
  assign vin[2] = req.vec.z;

  always_comb begin
    big_any   = |(m_r[0][CROSS_W-1:MAG_KEEP] | m_r[1][CROSS_W-1:MAG_KEEP] |
                  m_r[2][CROSS_W-1:MAG_KEEP]);
    sq_in     = m_r[scnt_r][MAG_KEEP-1:0];
    trial_s   = res_r + bit_r;
    s_ge      = (s_r >= trial_s);
    res_step  = s_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
    num       = DIV_W'({m_r[ccnt_r][MAG_KEEP-1:0], {Q_FRAC{1'b0}}}) + DIV_W'(len_r >> 1);
    trial_d   = DIV_W'(len_r) << qidx_r;
    d_ge      = (rem_r >= trial_d);
    qacc_step = d_ge ? (qacc_r | (Q_W'(1) << qidx_r)) : qacc_r;
    if (len_r == '0) begin
      qcap = '0;
    end else begin
      qcap = (qacc_step > Q14_ONE) ? Q14_ONE : qacc_step;
    end
    for (int i = 0; i < 3; i++) begin
      nval[i] = neg_r[i] ? -$signed({1'b0, q_r[i]}) : $signed({1'b0, q_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      NS_IDLE:     if (req.start) state_nxt = NS_SHIFT;
      NS_SHIFT:    if (!big_any) state_nxt = NS_SQUARE;
      NS_SQUARE:   if (scnt_r == 2'd3) state_nxt = NS_SQRT;
      NS_SQRT:     if (bit_r == ACC_W'(1)) state_nxt = NS_DIV_LOAD;
      NS_DIV_LOAD: state_nxt = NS_DIV;
      NS_DIV: begin
        if (qidx_r == '0) state_nxt = (ccnt_r == 2'd2) ? NS_DONE : NS_DIV_LOAD;
      end
      NS_DONE:     state_nxt = NS_IDLE;
      default:     state_nxt = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      NS_IDLE: begin
        if (req.start) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vin[i][CROSS_W-1];
            m_r[i]   <= vin[i][CROSS_W-1] ? unsigned'(-vin[i]) : unsigned'(vin[i]);
          end
        end
      end
      NS_SHIFT: begin
        if (big_any) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end else begin
          s_r    <= '0;
          scnt_r <= '0;
        end
      end
      NS_SQUARE: begin
        if (scnt_r != 2'd3) sq_r <= sq_in * sq_in;
        if (scnt_r != 2'd0) s_r <= s_r + ACC_W'(sq_r);
        scnt_r <= scnt_r + 1'b1;
        bit_r  <= SQRT_TOP;
        res_r  <= '0;
      end
      NS_SQRT: begin
        if (s_ge) s_r <= s_r - trial_s;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        len_r  <= res_step[ROOT_W-1:0];
        ccnt_r <= '0;
      end
      NS_DIV_LOAD: begin
        rem_r  <= num;
        qidx_r <= 4'(Q_FRAC);
        qacc_r <= '0;
      end
      NS_DIV: begin
        if (d_ge) rem_r <= rem_r - trial_d;
        qacc_r <= qacc_step;
        qidx_r <= qidx_r - 1'b1;
        if (qidx_r == '0) begin
          q_r[ccnt_r] <= qcap;
          ccnt_r      <= ccnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = (state_r == NS_DONE);
  assign rsp.n.x  = nval[0];
  assign rsp.n.y  = nval[1];
  assign rsp.n.z  = nval[2];

endmodule

// File: hdl/vna_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator back end
// Runs one job at a time against the position and normal-sum memories,
// forms cross products, drives the normalizer and holds the result beat.
// ----------------------------------------------------------------------------
module vna_back #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  vna_pkg::job_t       q_rdata,
  output logic                out_valid,
  input  logic                out_stall,
  output vna_pkg::out_item_t  out_data,
  output vna_pkg::norm_req_t  norm_req,
  input  vna_pkg::norm_rsp_t  norm_rsp
);
  import vna_pkg::*;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam logic [2:0] MUL_LAST = 3'd5;

  back_state_t               state_r, state_nxt;
  job_t                      job_r;
  logic [1:0]                kcnt_r, tcnt_r;
  logic [2:0]                mstep_r;
  pos3_t                     pos_r [4];
  logic signed [DIFF_W-1:0]  e1_r [3];
  logic signed [DIFF_W-1:0]  e2_r [3];
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [CROSS_W-1:0] cross_r [3];
  nrm3_t                     n_r;

  pos3_t                     pos_mem [MAX_VERTICES];
  sum3_t                     sum_mem [MAX_VERTICES];
  pos3_t                     pos_rd_r;
  sum3_t                     sum_rd_r;

  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic [1:0]                isel;
  logic [ADDR_W-1:0]         addr;
  logic                      pos_we, sum_we;
  sum3_t                     sum_wdata;
  logic                      is_quad;
  pos3_t                     pq;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic [1:0]                comp;
  logic [1:0]                status;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [NRM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = (SUM_W + 1)'(a) + (SUM_W + 1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  assign is_quad = (job_r.op == OP_QUAD);
  assign pq      = is_quad ? pos_r[3] : pos_r[2];
  assign comp    = mstep_r[2:1];

  always_comb begin
    case (state_r)
      BS_POS_RD:            isel = kcnt_r;
      BS_ACC_RD, BS_ACC_WR: isel = is_quad ? kcnt_r : tcnt_r;
      default:              isel = 2'd0;
    endcase
    addr = job_r.idx[isel][ADDR_W-1:0];
  end

  always_comb begin
    case (mstep_r)
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
      3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
      3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
      3'd5:    begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
      default: begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
    endcase
  end

  always_comb begin
    case (job_r.op)
      OP_SKIP: status = ST_SKIP;
      OP_BAD:  status = ST_BAD;
      default: status = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[addr] <= job_r.pos;
    pos_rd_r <= pos_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[addr] <= sum_wdata;
    sum_rd_r <= sum_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    q_pop          = 1'b0;
    pos_we         = 1'b0;
    sum_we         = 1'b0;
    sum_wdata      = '0;
    norm_req.start = 1'b0;
    norm_req.vec.x = cross_r[0];
    norm_req.vec.y = cross_r[1];
    norm_req.vec.z = cross_r[2];
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_rdata.op) inside
            OP_LOAD:          state_nxt = BS_LOAD;
            OP_TRI, OP_QUAD:  state_nxt = BS_POS_RD;
            OP_READ:          state_nxt = BS_SUM_RD;
            default:          state_nxt = BS_RESULT;
          endcase
        end
      end
      BS_LOAD: begin
        pos_we    = 1'b1;
        sum_we    = 1'b1;
        state_nxt = BS_RESULT;
      end
      BS_POS_RD:  state_nxt = BS_POS_CAP;
      BS_POS_CAP: begin
        if (kcnt_r == (is_quad ? 2'd3 : 2'd2)) state_nxt = BS_DIFF;
        else state_nxt = BS_POS_RD;
      end
      BS_DIFF: state_nxt = BS_MUL;
      BS_MUL:  state_nxt = BS_MACC;
      BS_MACC: state_nxt = (mstep_r == MUL_LAST) ? BS_NORM_GO : BS_MUL;
      BS_NORM_GO: begin
        norm_req.start = 1'b1;
        state_nxt      = BS_NORM_WAIT;
      end
      BS_SUM_RD: state_nxt = BS_SUM_CAP;
      BS_SUM_CAP: begin
        norm_req.start = 1'b1;
        norm_req.vec.x = CROSS_W'(sum_rd_r.x);
        norm_req.vec.y = CROSS_W'(sum_rd_r.y);
        norm_req.vec.z = CROSS_W'(sum_rd_r.z);
        state_nxt      = BS_NORM_WAIT;
      end
      BS_NORM_WAIT: begin
        if (norm_rsp.done) state_nxt = (job_r.op == OP_READ) ? BS_RESULT : BS_ACC_RD;
      end
      BS_ACC_RD: state_nxt = BS_ACC_WR;
      BS_ACC_WR: begin
        sum_we      = 1'b1;
        sum_wdata.x = sat_add(sum_rd_r.x, n_r.x);
        sum_wdata.y = sat_add(sum_rd_r.y, n_r.y);
        sum_wdata.z = sat_add(sum_rd_r.z, n_r.z);
        if (is_quad) state_nxt = (kcnt_r == 2'd3) ? BS_RESULT : BS_DIFF;
        else state_nxt = (tcnt_r == 2'd2) ? BS_RESULT : BS_ACC_RD;
      end
      BS_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = status;
          if (job_r.op == OP_READ) begin
            out_data_nxt.normal_x = n_r.x;
            out_data_nxt.normal_y = n_r.y;
            out_data_nxt.normal_z = n_r.z;
          end else begin
            out_data_nxt.normal_x = '0;
            out_data_nxt.normal_y = '0;
            out_data_nxt.normal_z = '0;
          end
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        job_r  <= q_rdata;
        kcnt_r <= '0;
      end
      BS_POS_CAP: begin
        pos_r[kcnt_r] <= pos_rd_r;
        kcnt_r        <= (kcnt_r == (is_quad ? 2'd3 : 2'd2)) ? 2'd0 : kcnt_r + 1'b1;
      end
      BS_DIFF: begin
        e1_r[0] <= DIFF_W'(pos_r[1].x) - DIFF_W'(pos_r[0].x);
        e1_r[1] <= DIFF_W'(pos_r[1].y) - DIFF_W'(pos_r[0].y);
        e1_r[2] <= DIFF_W'(pos_r[1].z) - DIFF_W'(pos_r[0].z);
        e2_r[0] <= DIFF_W'(pq.x) - DIFF_W'(pos_r[0].x);
        e2_r[1] <= DIFF_W'(pq.y) - DIFF_W'(pos_r[0].y);
        e2_r[2] <= DIFF_W'(pq.z) - DIFF_W'(pos_r[0].z);
        mstep_r <= '0;
      end
      BS_MUL: prod_r <= mul_a * mul_b;
      BS_MACC: begin
        if (!mstep_r[0]) cross_r[comp] <= CROSS_W'(prod_r);
        else cross_r[comp] <= cross_r[comp] - CROSS_W'(prod_r);
        mstep_r <= mstep_r + 1'b1;
      end
      BS_NORM_WAIT: begin
        if (norm_rsp.done) n_r <= norm_rsp.n;
        tcnt_r <= '0;
      end
      BS_ACC_WR: begin
        if (is_quad) begin
          kcnt_r   <= kcnt_r + 1'b1;
          pos_r[0] <= pos_r[1];
          pos_r[1] <= pos_r[2];
          pos_r[2] <= pos_r[3];
          pos_r[3] <= pos_r[0];
        end else begin
          tcnt_r <= tcnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    norm_rsp.done |-> state_r == BS_NORM_WAIT)
    else $error("normalizer finished while the back end was not waiting");

  a_result_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == BS_RESULT)
    else $error("result beat appeared outside the result state");

  a_sum_write_job: assert property (@(posedge clk) disable iff (!rst_n)
    sum_we |-> (job_r.op == OP_LOAD || job_r.op == OP_TRI || job_r.op == OP_QUAD))
    else $error("normal sum written by a job that must not change it");

  a_leave_idle_popped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BS_IDLE && $past(state_r) == BS_IDLE) |-> $past(q_pop))
    else $error("back end started without taking a job");

endmodule

// File: hdl/vertex_normal_accumulator.sv
`timescale 1ns / 1ps
// The back end takes one item at a time; each normalization first shifts the magnitudes down,
// up to 19 times for a cross product and 2 for a normal sum.
// A two-beat queue lets the next item be taken while the current one runs.
// Reset clears control and vertex_count; the vertex and sum memories are not cleared.
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Per-vertex normals of a triangle and quad mesh, averaged in Q1.14.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
  parameter int QUEUE_DEPTH  = vna_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  vna_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output vna_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [vna_pkg::CNT_W-1:0] cfg_data
);
  import vna_pkg::*;

  logic      q_push, q_full, q_pop, q_valid;
  job_t      q_wdata, q_rdata;
  norm_req_t norm_req;
  norm_rsp_t norm_rsp;

  vna_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  vna_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  vna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (norm_req),
    .rsp   (norm_rsp)
  );

  vna_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .norm_req  (norm_req),
    .norm_rsp  (norm_rsp)
  );

endmodule
